### sv/cna_pkg.sv
// ============================================================================
// cna_pkg
// Shared constants and types for the complex number alu.
// ============================================================================
`default_nettype none

package cna_pkg;

   localparam int DATA_WIDTH_DEF = 16;
   localparam int FRAC_BITS_DEF  = 8;
   localparam int CMD_WIDTH      = 2;
   localparam int STATUS_WIDTH   = 2;

   typedef enum logic [CMD_WIDTH-1:0] {
      CMD_ADD = 2'd0,
      CMD_SUB = 2'd1,
      CMD_MUL = 2'd2,
      CMD_DIV = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_WIDTH-1:0] {
      STATUS_OK      = 2'd0,
      STATUS_DIV0    = 2'd1,
      STATUS_SAT     = 2'd2,
      STATUS_UNUSED  = 2'd3
   } status_type;

   // flags that travel down the pipeline with each transaction
   typedef struct packed {
      logic    valid;
      cmd_type cmd;
      logic    div0;
   } ctrl_type;

endpackage

`default_nettype wire

### sv/cna_prod.sv
// ============================================================================
// cna_prod
// Product stage: registered operands, four cross products and the two squares
// of b, then combine into real and imaginary sums (or plain add/sub) and the denominator.
// ============================================================================
`default_nettype none

module cna_prod #(
   parameter int DATA_WIDTH = cna_pkg::DATA_WIDTH_DEF
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          advance,
   input  wire cna_pkg::ctrl_type             ctrl_in,
   input  wire logic signed [DATA_WIDTH-1:0]  a_re,
   input  wire logic signed [DATA_WIDTH-1:0]  a_im,
   input  wire logic signed [DATA_WIDTH-1:0]  b_re,
   input  wire logic signed [DATA_WIDTH-1:0]  b_im,
   output cna_pkg::ctrl_type                  ctrl_out,
   output logic signed [2*DATA_WIDTH+1:0]     sum_re,
   output logic signed [2*DATA_WIDTH+1:0]     sum_im,
   output logic [2*DATA_WIDTH:0]              den
);

   localparam int PW = 2 * DATA_WIDTH;
   localparam int SW = 2 * DATA_WIDTH + 2;

   cna_pkg::ctrl_type ctrl1_ff, ctrl2_ff;
   logic signed [PW-1:0] p_rr_ff, p_ii_ff, p_ri_ff, p_ir_ff, p_brr_ff, p_bii_ff;
   logic signed [DATA_WIDTH-1:0] ar_ff, ai_ff, br_ff, bi_ff;
   logic signed [SW-1:0] sum_re_ff, sum_im_ff;
   logic [PW:0] den_ff;
   logic signed [SW-1:0] sre_in, sim_in;

   // stage 1: multiplies
   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl1_ff <= '0;
      end else if (advance) begin
         ctrl1_ff <= ctrl_in;
      end
      if (advance) begin
         p_rr_ff  <= a_re * b_re;
         p_ii_ff  <= a_im * b_im;
         p_ri_ff  <= a_re * b_im;
         p_ir_ff  <= a_im * b_re;
         p_brr_ff <= b_re * b_re;
         p_bii_ff <= b_im * b_im;
         ar_ff    <= a_re;
         ai_ff    <= a_im;
         br_ff    <= b_re;
         bi_ff    <= b_im;
      end
   end

   // combine by operation
   always_comb begin
      case (ctrl1_ff.cmd)
         cna_pkg::CMD_ADD: begin
            sre_in = SW'(ar_ff) + SW'(br_ff);
            sim_in = SW'(ai_ff) + SW'(bi_ff);
         end
         cna_pkg::CMD_SUB: begin
            sre_in = SW'(ar_ff) - SW'(br_ff);
            sim_in = SW'(ai_ff) - SW'(bi_ff);
         end
         cna_pkg::CMD_MUL: begin
            sre_in = SW'(p_rr_ff) - SW'(p_ii_ff);
            sim_in = SW'(p_ri_ff) + SW'(p_ir_ff);
         end
         default: begin
            sre_in = SW'(p_rr_ff) + SW'(p_ii_ff);
            sim_in = SW'(p_ir_ff) - SW'(p_ri_ff);
         end
      endcase
   end

   // stage 2: sums and denominator
   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl2_ff <= '0;
      end else if (advance) begin
         ctrl2_ff <= ctrl1_ff;
      end
      if (advance) begin
         sum_re_ff <= sre_in;
         sum_im_ff <= sim_in;
         den_ff    <= {1'b0, p_brr_ff} + {1'b0, p_bii_ff};
      end
   end

   assign ctrl_out = ctrl2_ff;
   assign sum_re   = sum_re_ff;
   assign sum_im   = sum_im_ff;
   assign den      = den_ff;

endmodule

`default_nettype wire

### sv/cna_div.sv
// ============================================================================
// cna_div
// Pipelined restoring divider: one quotient bit per stage, magnitude in,
// truncated magnitude out; the sign is reapplied outside the divider.
// ============================================================================
`default_nettype none

module cna_div #(
   parameter int NUM_WIDTH = 42,
   parameter int DEN_WIDTH = 33
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  advance,
   input  wire logic                  valid_in,
   input  wire logic [NUM_WIDTH-1:0]  num_in,
   input  wire logic [DEN_WIDTH-1:0]  den_in,
   output logic [NUM_WIDTH-1:0]       quo_out
);

   localparam int RW = DEN_WIDTH + 1;

   logic [NUM_WIDTH-1:0] num_ff [NUM_WIDTH+1];
   logic [NUM_WIDTH-1:0] quo_ff [NUM_WIDTH+1];
   logic [RW-1:0]        rem_ff [NUM_WIDTH+1];
   logic [DEN_WIDTH-1:0] den_ff [NUM_WIDTH+1];
   logic                 vld_ff [NUM_WIDTH+1];

   always_comb begin
      num_ff[0] = num_in;
      quo_ff[0] = '0;
      rem_ff[0] = '0;
      den_ff[0] = den_in;
      vld_ff[0] = valid_in;
   end

   // one quotient bit per stage, msb first
   for (genvar s = 0; s < NUM_WIDTH; s++) begin : g_stage
      logic [RW:0] trial;
      logic        take;
      assign trial = {rem_ff[s], num_ff[s][NUM_WIDTH-1-s]};
      assign take  = trial >= {2'b00, den_ff[s]};
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[s+1] <= 1'b0;
         end else if (advance) begin
            vld_ff[s+1] <= vld_ff[s];
         end
         if (advance) begin
            rem_ff[s+1] <= take ? RW'(trial - {2'b00, den_ff[s]}) : RW'(trial);
            quo_ff[s+1] <= quo_ff[s] | (NUM_WIDTH'(take) << (NUM_WIDTH-1-s));
            num_ff[s+1] <= num_ff[s];
            den_ff[s+1] <= den_ff[s];
         end
      end
   end

   assign quo_out = quo_ff[NUM_WIDTH] & {NUM_WIDTH{vld_ff[NUM_WIDTH] | 1'b1}};

endmodule

`default_nettype wire

### sv/complex_number_alu.sv
// ============================================================================
// complex_number_alu
// Complex add, subtract, multiply and divide in signed fixed point.
//
//  channel  direction  ports
//  req      in         req_valid, req_stall, req_cmd, req_a_*, req_b_*
//  rsp      out        rsp_valid, rsp_stall, rsp_res_re, rsp_res_im, rsp_status
//
// One transaction per cycle while a held result does not stall rsp. Every
// operation, not only divide, passes through the full divider pipeline (one
// quotient bit per stage) before its result is presented.
// Synchronous reset clears all valid bits. A stalled rsp freezes the whole
// pipeline; req_stall follows rsp_stall so no transaction is lost.
// ============================================================================
`default_nettype none

module complex_number_alu #(
   parameter int DATA_WIDTH = cna_pkg::DATA_WIDTH_DEF,
   parameter int FRAC_BITS  = cna_pkg::FRAC_BITS_DEF
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_valid,
   output logic                                    req_stall,
   input  wire logic [cna_pkg::CMD_WIDTH-1:0]      req_cmd,
   input  wire logic signed [DATA_WIDTH-1:0]       req_a_re,
   input  wire logic signed [DATA_WIDTH-1:0]       req_a_im,
   input  wire logic signed [DATA_WIDTH-1:0]       req_b_re,
   input  wire logic signed [DATA_WIDTH-1:0]       req_b_im,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_stall,
   output logic signed [DATA_WIDTH-1:0]            rsp_res_re,
   output logic signed [DATA_WIDTH-1:0]            rsp_res_im,
   output logic [cna_pkg::STATUS_WIDTH-1:0]        rsp_status
);

   localparam int SW  = 2 * DATA_WIDTH + 2;
   localparam int MW  = SW + FRAC_BITS;       // dividend magnitude width
   localparam int DW  = 2 * DATA_WIDTH + 1;
   localparam int LAT = MW;                   // divider depth
   localparam logic signed [SW-1:0] MAXV = SW'((64'sd1 <<< (DATA_WIDTH-1)) - 1);
   localparam logic signed [SW-1:0] MINV = -SW'(64'sd1 <<< (DATA_WIDTH-1));

   logic advance;
   cna_pkg::ctrl_type ctrl_in, ctrl2;
   logic signed [SW-1:0] sum_re, sum_im;
   logic [DW-1:0] den;

   // whole pipeline moves unless a held result blocks it
   assign advance   = !(rsp_valid && rsp_stall);
   assign req_stall = !advance;

   always_comb begin
      ctrl_in.valid = req_valid;
      ctrl_in.cmd   = cna_pkg::cmd_type'(req_cmd);
      ctrl_in.div0  = (req_b_re == '0) && (req_b_im == '0);
   end

   cna_prod #(.DATA_WIDTH(DATA_WIDTH)) u_prod (
      .clock, .reset, .advance, .ctrl_in,
      .a_re(req_a_re), .a_im(req_a_im), .b_re(req_b_re), .b_im(req_b_im),
      .ctrl_out(ctrl2), .sum_re, .sum_im, .den
   );

   // magnitudes, floor shift for multiply
   logic [MW-1:0] mag_re, mag_im;
   logic neg_re, neg_im;
   logic signed [SW-1:0] fl_re, fl_im;
   assign neg_re = sum_re[SW-1];
   assign neg_im = sum_im[SW-1];
   assign mag_re = MW'(neg_re ? -sum_re : sum_re) << FRAC_BITS;
   assign mag_im = MW'(neg_im ? -sum_im : sum_im) << FRAC_BITS;
   assign fl_re  = sum_re >>> FRAC_BITS;
   assign fl_im  = sum_im >>> FRAC_BITS;

   logic [MW-1:0] q_re, q_im;
   logic [DW-1:0] den_safe;
   assign den_safe = (den == '0) ? DW'(1) : den;

   cna_div #(.NUM_WIDTH(MW), .DEN_WIDTH(DW)) u_div_re (
      .clock, .reset, .advance, .valid_in(ctrl2.valid),
      .num_in(mag_re), .den_in(den_safe), .quo_out(q_re)
   );
   cna_div #(.NUM_WIDTH(MW), .DEN_WIDTH(DW)) u_div_im (
      .clock, .reset, .advance, .valid_in(ctrl2.valid),
      .num_in(mag_im), .den_in(den_safe), .quo_out(q_im)
   );

   // side delay line matching the divider depth
   cna_pkg::ctrl_type    dctrl_ff [LAT];
   logic signed [SW-1:0] dre_ff   [LAT];
   logic signed [SW-1:0] dim_ff   [LAT];
   logic                 dnr_ff   [LAT];
   logic                 dni_ff   [LAT];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < LAT; i++) dctrl_ff[i].valid <= 1'b0;
      end else if (advance) begin
         dctrl_ff[0].valid <= ctrl2.valid;
         for (int i = 1; i < LAT; i++) dctrl_ff[i].valid <= dctrl_ff[i-1].valid;
      end
      if (advance) begin
         dctrl_ff[0].cmd  <= ctrl2.cmd;
         dctrl_ff[0].div0 <= ctrl2.div0;
         dre_ff[0] <= (ctrl2.cmd == cna_pkg::CMD_MUL) ? fl_re : sum_re;
         dim_ff[0] <= (ctrl2.cmd == cna_pkg::CMD_MUL) ? fl_im : sum_im;
         dnr_ff[0] <= neg_re;
         dni_ff[0] <= neg_im;
         for (int i = 1; i < LAT; i++) begin
            dctrl_ff[i].cmd  <= dctrl_ff[i-1].cmd;
            dctrl_ff[i].div0 <= dctrl_ff[i-1].div0;
            dre_ff[i] <= dre_ff[i-1];
            dim_ff[i] <= dim_ff[i-1];
            dnr_ff[i] <= dnr_ff[i-1];
            dni_ff[i] <= dni_ff[i-1];
         end
      end
   end

   // select, signed quotient, saturate
   cna_pkg::ctrl_type ce;
   logic signed [MW:0] v_re, v_im;
   logic signed [MW:0] qs_re, qs_im;
   logic sat_re, sat_im;
   logic signed [DATA_WIDTH-1:0] o_re_in, o_im_in;
   logic [cna_pkg::STATUS_WIDTH-1:0] st_in;
   assign ce = dctrl_ff[LAT-1];
   assign qs_re = dnr_ff[LAT-1] ? -$signed({1'b0, q_re}) : $signed({1'b0, q_re});
   assign qs_im = dni_ff[LAT-1] ? -$signed({1'b0, q_im}) : $signed({1'b0, q_im});

   always_comb begin
      if (ce.cmd == cna_pkg::CMD_DIV) begin
         v_re = qs_re;
         v_im = qs_im;
      end else begin
         v_re = (MW+1)'(dre_ff[LAT-1]);
         v_im = (MW+1)'(dim_ff[LAT-1]);
      end
      sat_re = (v_re > (MW+1)'(MAXV)) || (v_re < (MW+1)'(MINV));
      sat_im = (v_im > (MW+1)'(MAXV)) || (v_im < (MW+1)'(MINV));
      o_re_in = sat_re ? (v_re[MW] ? DATA_WIDTH'(MINV) : DATA_WIDTH'(MAXV))
                       : DATA_WIDTH'(v_re);
      o_im_in = sat_im ? (v_im[MW] ? DATA_WIDTH'(MINV) : DATA_WIDTH'(MAXV))
                       : DATA_WIDTH'(v_im);
      st_in = (sat_re || sat_im) ? cna_pkg::STATUS_SAT : cna_pkg::STATUS_OK;
      if (ce.cmd == cna_pkg::CMD_DIV && ce.div0) begin
         o_re_in = '0;
         o_im_in = '0;
         st_in   = cna_pkg::STATUS_DIV0;
      end
   end

   // output register
   logic rsp_valid_ff;
   logic signed [DATA_WIDTH-1:0] rsp_re_ff, rsp_im_ff;
   logic [cna_pkg::STATUS_WIDTH-1:0] rsp_st_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= ce.valid;
      end
      if (advance) begin
         rsp_re_ff <= o_re_in;
         rsp_im_ff <= o_im_in;
         rsp_st_ff <= st_in;
      end
   end

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_res_re = rsp_re_ff;
   assign rsp_res_im = rsp_im_ff;
   assign rsp_status = rsp_st_ff;

`ifndef NO_ASSERTIONS
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_res_re))
      else $error("result changed under stall");
   a_div0_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == cna_pkg::STATUS_DIV0 |-> rsp_res_re == '0)
      else $error("divide by zero result not zero");
   a_req_stall: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without cause");
`endif

endmodule

`default_nettype wire

### verif/complex_number_alu_test.sv
// ============================================================================
// complex_number_alu_test
// Self-checking bench for the complex alu: directed corner operands, then
// random operand pairs with random idling on both channels; every result is
// compared against an in-bench fixed point model through a small scoreboard.
// ============================================================================
`timescale 1ns / 1ps
`default_nettype none

module complex_number_alu_test;

   localparam int DW = 16;
   localparam int FB = 8;
   localparam int PIPE_LAT = 2*DW + FB + 6;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int NUM_RANDOM = 1200;

   localparam longint SAT_MAX = (64'sd1 <<< (DW-1)) - 1;
   localparam longint SAT_MIN = -(64'sd1 <<< (DW-1));

   typedef struct {
      logic signed [DW-1:0]                 re;
      logic signed [DW-1:0]                 im;
      logic [cna_pkg::STATUS_WIDTH-1:0]     status;
   } alu_result_type;

   // expected results in issue order
   class scoreboard_type;
      alu_result_type pending[$];
      int        errors;
      int        checked;
      int        op_count[4];
      int        sat_count;
      int        div0_count;

      // clamp to the output range and note whether it clamped
      function automatic logic signed [DW-1:0] clamp_part(longint v, ref bit clipped);
         if (v > SAT_MAX) begin
            clipped = 1;
            return SAT_MAX[DW-1:0];
         end
         if (v < SAT_MIN) begin
            clipped = 1;
            return SAT_MIN[DW-1:0];
         end
         return v[DW-1:0];
      endfunction

      // quotient of (n << FB) / d truncated toward zero
      function automatic longint quot_trunc(longint n, longint d);
         longint q;
         q = ((n < 0 ? -n : n) <<< FB) / d;
         return (n < 0) ? -q : q;
      endfunction

      function automatic void note_transaction(cna_pkg::cmd_type cmd,
            logic signed [DW-1:0] ar, logic signed [DW-1:0] ai,
            logic signed [DW-1:0] br, logic signed [DW-1:0] bi);
         alu_result_type r;
         longint xr, xi, a_r, a_i, b_r, b_i, den;
         bit clipped;
         a_r = ar; a_i = ai; b_r = br; b_i = bi;
         clipped = 0;
         op_count[cmd]++;
         case (cmd)
            cna_pkg::CMD_ADD: begin
               xr = a_r + b_r; xi = a_i + b_i;
            end
            cna_pkg::CMD_SUB: begin
               xr = a_r - b_r; xi = a_i - b_i;
            end
            cna_pkg::CMD_MUL: begin
               xr = (a_r*b_r - a_i*b_i) >>> FB;
               xi = (a_r*b_i + a_i*b_r) >>> FB;
            end
            default: begin
               den = b_r*b_r + b_i*b_i;
               if (den == 0) begin
                  r.re = '0; r.im = '0; r.status = cna_pkg::STATUS_DIV0;
                  div0_count++;
                  pending.push_back(r);
                  return;
               end
               xr = quot_trunc(a_r*b_r + a_i*b_i, den);
               xi = quot_trunc(a_i*b_r - a_r*b_i, den);
            end
         endcase
         r.re = clamp_part(xr, clipped);
         r.im = clamp_part(xi, clipped);
         r.status = clipped ? cna_pkg::STATUS_SAT : cna_pkg::STATUS_OK;
         if (clipped) sat_count++;
         pending.push_back(r);
      endfunction

      function automatic void check_result(logic signed [DW-1:0] re,
            logic signed [DW-1:0] im, logic [cna_pkg::STATUS_WIDTH-1:0] status);
         alu_result_type e;
         if (pending.size() == 0) begin
            $error("unexpected result re=%0d im=%0d status=%0d", re, im, status);
            errors++;
            return;
         end
         e = pending.pop_front();
         checked++;
         if (re !== e.re) begin
            $error("res_re expected %0d actual %0d", e.re, re); errors++;
         end
         if (im !== e.im) begin
            $error("res_im expected %0d actual %0d", e.im, im); errors++;
         end
         if (status !== e.status) begin
            $error("status expected %0d actual %0d", e.status, status); errors++;
         end
      endfunction
   endclass

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0;
   logic req_stall;
   logic [cna_pkg::CMD_WIDTH-1:0] req_cmd = '0;
   logic signed [DW-1:0] req_a_re = '0, req_a_im = '0, req_b_re = '0, req_b_im = '0;
   logic rsp_valid;
   logic rsp_stall = 0;
   logic signed [DW-1:0] rsp_res_re, rsp_res_im;
   logic [cna_pkg::STATUS_WIDTH-1:0] rsp_status;

   scoreboard_type sb = new();
   bit idle_off = 0;
   bit hold_rsp = 0;
   int quiet_cycles = 0;

   always #6 clock = ~clock;

   complex_number_alu #(.DATA_WIDTH(DW), .FRAC_BITS(FB)) dut (.*);

   // result side: sample, check, random stall bursts
   always @(posedge clock) begin
      int burst;
      if (!reset) begin
         if (rsp_valid && !rsp_stall)
            sb.check_result(rsp_res_re, rsp_res_im, rsp_status);
         if (hold_rsp)
            rsp_stall <= 1;
         else if (burst > 0) begin
            burst--;
            rsp_stall <= 1;
         end else if (!idle_off && $urandom_range(0, 5) == 0) begin
            burst = $urandom_range(0, 2);
            rsp_stall <= 1;
         end else
            rsp_stall <= 0;
      end
   end

   // watchdog on cycles with no transaction on either channel
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || reset || hold_rsp)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles > WATCHDOG_LIMIT) begin
         $display("watchdog expired");
         $display("Regression FAIL");
         $finish;
      end
   end

   function automatic logic signed [DW-1:0] pick_operand();
      case ($urandom_range(0, 7))
         0: return SAT_MAX[DW-1:0];
         1: return SAT_MIN[DW-1:0];
         2: return '0;
         3: return DW'($urandom_range(0, 1023) - 512);
         default: return DW'($urandom());
      endcase
   endfunction

   // offer one transaction and hold it until accepted
   task automatic send_transaction(cna_pkg::cmd_type cmd, logic signed [DW-1:0] ar,
         logic signed [DW-1:0] ai, logic signed [DW-1:0] br, logic signed [DW-1:0] bi);
      int gap;
      if (!idle_off && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 3);
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1;
      req_cmd <= cmd;
      req_a_re <= ar; req_a_im <= ai; req_b_re <= br; req_b_im <= bi;
      do @(posedge clock); while (req_stall);
      sb.note_transaction(cmd, ar, ai, br, bi);
   endtask

   task automatic drain();
      req_valid <= 0;
      while (sb.pending.size() != 0) @(posedge clock);
   endtask

   initial begin
      logic signed [DW-1:0] mx, mn;
      mx = SAT_MAX[DW-1:0];
      mn = SAT_MIN[DW-1:0];
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // directed corners
      send_transaction(cna_pkg::CMD_ADD, mx, mn, mx, mn);
      send_transaction(cna_pkg::CMD_ADD, 16'sd256, -16'sd256, 16'sd1, 16'sd0);
      send_transaction(cna_pkg::CMD_SUB, mn, mx, mx, mn);
      send_transaction(cna_pkg::CMD_SUB, 16'sd100, 16'sd5, 16'sd100, 16'sd5);
      send_transaction(cna_pkg::CMD_MUL, mn, mn, mn, mn);
      send_transaction(cna_pkg::CMD_MUL, mx, mn, mn, mx);
      send_transaction(cna_pkg::CMD_MUL, -16'sd1, 16'sd1, 16'sd1, 16'sd1);
      send_transaction(cna_pkg::CMD_MUL, 16'sd256, 16'sd0, 16'sd256, 16'sd0);
      send_transaction(cna_pkg::CMD_DIV, 16'sd256, 16'sd256, 16'sd0, 16'sd0);
      send_transaction(cna_pkg::CMD_DIV, mx, mn, 16'sd0, 16'sd0);
      send_transaction(cna_pkg::CMD_DIV, mx, mx, 16'sd1, 16'sd0);
      send_transaction(cna_pkg::CMD_DIV, mn, mn, mn, mn);
      send_transaction(cna_pkg::CMD_DIV, -16'sd1, 16'sd1, mx, mx);
      send_transaction(cna_pkg::CMD_DIV, 16'sd512, -16'sd256, 16'sd256, 16'sd256);
      send_transaction(cna_pkg::CMD_DIV, 16'sd0, 16'sd0, mn, 16'sd0);

      // sender pauses until everything has come back
      drain();

      // receiver holds off while the sender keeps offering
      fork
         begin
            hold_rsp = 1;
            repeat (200) @(posedge clock);
            hold_rsp = 0;
         end
         repeat (120) send_transaction(cna_pkg::cmd_type'($urandom_range(0, 3)),
            pick_operand(), pick_operand(), pick_operand(), pick_operand());
      join

      // random stream, last part with no idling
      for (int i = 0; i < NUM_RANDOM; i++) begin
         cna_pkg::cmd_type c;
         logic signed [DW-1:0] br, bi;
         if (i == NUM_RANDOM - 200) idle_off = 1;
         c = cna_pkg::cmd_type'($urandom_range(0, 3));
         br = pick_operand();
         bi = pick_operand();
         if (c == cna_pkg::CMD_DIV && $urandom_range(0, 15) == 0) begin
            br = '0; bi = '0;
         end
         send_transaction(c, pick_operand(), pick_operand(), br, bi);
      end
      drain();
      repeat (PIPE_LAT + 10) @(posedge clock);

      $display("checked %0d results: add %0d sub %0d mul %0d div %0d, %0d saturated, %0d div0",
         sb.checked, sb.op_count[0], sb.op_count[1], sb.op_count[2], sb.op_count[3],
         sb.sat_count, sb.div0_count);
      if (sb.errors == 0 && sb.pending.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end
endmodule

`default_nettype wire
